// ----- hdl/mm4_pkg.sv -----
// shared types, constants and codes of the 4x4 fixed-point matrix multiplier
package mm4_pkg;

   // matrix geometry and number format
   localparam int DIM       = 4;
   localparam int FRAC_BITS = 16;
   localparam int VAL_W     = 32;
   localparam int ROW_W     = 2;
   localparam int CODE_W    = 2;

   // derived widths
   localparam int DIM_W  = (DIM > 1) ? $clog2(DIM) : 1;
   localparam int IDX_W  = $clog2(DIM * DIM);
   localparam int PROD_W = 2 * VAL_W;
   localparam int ACC_W  = PROD_W + $clog2(DIM) + 1;

   // result queue depth, also the number of elements allowed in flight
   localparam int FIFO_DEPTH = 2;
   localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CREDIT_W   = $clog2(FIFO_DEPTH + 1);

   // saturation limits
   localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   // request codes
   localparam logic [CODE_W-1:0] REQ_WR_LEFT  = 2'd0;
   localparam logic [CODE_W-1:0] REQ_WR_RIGHT = 2'd1;
   localparam logic [CODE_W-1:0] REQ_COMPUTE  = 2'd2;

   typedef struct packed {
      logic [CODE_W-1:0]       req_type;
      logic [ROW_W-1:0]        row;
      logic [ROW_W-1:0]        col;
      logic signed [VAL_W-1:0] value;
   } mm4_req_type;

   typedef struct packed {
      logic [ROW_W-1:0]        out_row;
      logic [ROW_W-1:0]        out_col;
      logic signed [VAL_W-1:0] out_value;
      logic                    saturated;
      logic                    last;
   } mm4_rsp_type;

   // tag that travels down the multiply-accumulate pipeline
   typedef struct packed {
      logic             first;
      logic             last_k;
      logic             last;
      logic [ROW_W-1:0] row;
      logic [ROW_W-1:0] col;
   } mm4_tag_type;

   // controller to datapath
   typedef struct packed {
      logic             wr_left;
      logic             wr_right;
      logic [IDX_W-1:0] wr_idx;
      logic             rd_en;
      logic [IDX_W-1:0] rd_idx_l;
      logic [IDX_W-1:0] rd_idx_r;
      mm4_tag_type      tag;
   } mm4_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic pop;
   } mm4_sts_type;

endpackage

// ----- hdl/matrix_multiply_4x4.sv -----
// top level of the 4x4 signed Q16.16 matrix multiplier
// element writes: one transaction per cycle while no compute runs, no result
// compute: 16 results, one multiply-accumulate per cycle while the queue has room;
//   each result passes the store read, product and accumulator registers into the queue
// the single shared multiplier and the one read port per matrix store set that rate
// synchronous active-high reset clears control state; matrix contents hold until written
module matrix_multiply_4x4
   import mm4_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  mm4_req_type req_data,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output mm4_rsp_type rsp_data
);

   mm4_cmd_type cmd;
   mm4_sts_type sts;

   // controller decodes each transaction and walks i, j, k for a compute
   mm4_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath holds both matrices and the pipelined multiply-accumulate
   mm4_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .wr_value  (req_data.value),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // a compute transaction blocks further requests in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_data.req_type == REQ_COMPUTE)) |=> !req_ready)
      else $error("request accepted straight after a compute transaction");

   // store reads never overlap request acceptance
   assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |-> !req_ready)
      else $error("matrix read issued while requests are accepted");

   // the final read of a run ends the run
   assert property (@(posedge clock) disable iff (reset)
      (cmd.rd_en && cmd.tag.last) |=> !cmd.rd_en)
      else $error("reads continue after the final element of a run");

endmodule

// ----- hdl/mm4_ctrl.sv -----
// controller: request decode, element sequencing and result credit tracking
module mm4_ctrl
   import mm4_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  mm4_req_type req_data,
   input  mm4_sts_type sts,
   output mm4_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type           state_ff, state_in;
   logic [DIM_W-1:0]    i_ff, i_in;
   logic [DIM_W-1:0]    j_ff, j_in;
   logic [DIM_W-1:0]    k_ff, k_in;
   logic [CREDIT_W-1:0] credit_ff, credit_in;
   logic                accept;
   logic                issue;
   logic                in_range;
   logic                k_wrap, j_wrap, i_wrap;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign in_range  = (int'(req_data.row) < DIM) && (int'(req_data.col) < DIM);
   assign k_wrap    = (k_ff == DIM_W'(DIM - 1));
   assign j_wrap    = (j_ff == DIM_W'(DIM - 1));
   assign i_wrap    = (i_ff == DIM_W'(DIM - 1));

   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      issue     = 1'b0;
      cmd       = '0;
      cmd.wr_idx = IDX_W'(int'(req_data.row) * DIM + int'(req_data.col));
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.req_type)
                  REQ_WR_LEFT:  cmd.wr_left  = in_range;
                  REQ_WR_RIGHT: cmd.wr_right = in_range;
                  REQ_COMPUTE: begin
                     state_in = ST_RUN;
                     i_in     = '0;
                     j_in     = '0;
                     k_in     = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_RUN: begin
            // a new element starts only when the result queue has room for it
            issue = (k_ff != '0) || (credit_ff < CREDIT_W'(FIFO_DEPTH));
            if (issue) begin
               cmd.rd_en      = 1'b1;
               cmd.rd_idx_l   = IDX_W'(int'(i_ff) * DIM + int'(k_ff));
               cmd.rd_idx_r   = IDX_W'(int'(k_ff) * DIM + int'(j_ff));
               cmd.tag.first  = (k_ff == '0);
               cmd.tag.last_k = k_wrap;
               cmd.tag.last   = k_wrap && j_wrap && i_wrap;
               cmd.tag.row    = ROW_W'(i_ff);
               cmd.tag.col    = ROW_W'(j_ff);
               k_in = k_wrap ? '0 : k_ff + 1'b1;
               if (k_wrap) begin
                  j_in = j_wrap ? '0 : j_ff + 1'b1;
                  if (j_wrap) begin
                     i_in = i_wrap ? '0 : i_ff + 1'b1;
                     if (i_wrap) begin
                        state_in = ST_IDLE;
                     end
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign credit_in = credit_ff + CREDIT_W'(issue && (k_ff == '0)) - CREDIT_W'(sts.pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         i_ff      <= '0;
         j_ff      <= '0;
         k_ff      <= '0;
         credit_ff <= '0;
      end else begin
         state_ff  <= state_in;
         i_ff      <= i_in;
         j_ff      <= j_in;
         k_ff      <= k_in;
         credit_ff <= credit_in;
      end
   end

endmodule

// ----- hdl/mm4_datapath.sv -----
// datapath: matrix stores, multiply-accumulate pipeline, rounding, saturation, result queue
module mm4_datapath
   import mm4_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  mm4_cmd_type             cmd,
   input  logic signed [VAL_W-1:0] wr_value,
   output mm4_sts_type             sts,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output mm4_rsp_type             rsp_data
);

   logic signed [VAL_W-1:0] left_mem  [DIM*DIM];
   logic signed [VAL_W-1:0] right_mem [DIM*DIM];

   logic signed [VAL_W-1:0]  l_rd_ff, r_rd_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  shifted;
   logic [ACC_W-VAL_W:0]     upper;
   logic                     fits;

   logic        s1_valid_ff, s2_valid_ff, s3_valid_ff;
   mm4_tag_type s1_tag_ff, s2_tag_ff, s3_tag_ff;

   mm4_rsp_type         fifo_ff [FIFO_DEPTH];
   mm4_rsp_type         result;
   logic [PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CREDIT_W-1:0] count_ff, count_in;
   logic                push, pop;

   // matrix stores, one write and one registered read each
   always_ff @(posedge clock) begin
      if (cmd.wr_left) begin
         left_mem[cmd.wr_idx] <= wr_value;
      end
      if (cmd.wr_right) begin
         right_mem[cmd.wr_idx] <= wr_value;
      end
      if (cmd.rd_en) begin
         l_rd_ff <= left_mem[cmd.rd_idx_l];
         r_rd_ff <= right_mem[cmd.rd_idx_r];
      end
   end

   // multiply then accumulate
   assign acc_in = s2_tag_ff.first ? ACC_W'(prod_ff) : acc_ff + ACC_W'(prod_ff);

   always_ff @(posedge clock) begin
      s1_tag_ff <= cmd.tag;
      s2_tag_ff <= s1_tag_ff;
      s3_tag_ff <= s2_tag_ff;
      prod_ff   <= l_rd_ff * r_rd_ff;
      if (s2_valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.rd_en;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // round toward minus infinity, then clip to the 32-bit range
   assign shifted = acc_ff >>> FRAC_BITS;
   assign upper   = shifted[ACC_W-1:VAL_W-1];
   assign fits    = (&upper) || !(|upper);

   always_comb begin
      result.out_row   = s3_tag_ff.row;
      result.out_col   = s3_tag_ff.col;
      result.last      = s3_tag_ff.last;
      result.saturated = !fits;
      if (fits) begin
         result.out_value = shifted[VAL_W-1:0];
      end else if (shifted[ACC_W-1]) begin
         result.out_value = VAL_MIN;
      end else begin
         result.out_value = VAL_MAX;
      end
   end

   // result queue
   assign push      = s3_valid_ff && s3_tag_ff.last_k;
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_data  = fifo_ff[rd_ptr_ff];
   assign sts.pop   = pop;
   assign count_in  = count_ff + CREDIT_W'(push) - CREDIT_W'(pop);

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
      end
   end

endmodule

// ----- tb/sv/testbench.sv -----
// self-checking testbench of the 4x4 fixed-point matrix multiplier
`timescale 1ns / 100ps

module testbench
   import mm4_pkg::*;
();

   // request code that the block ignores
   localparam logic [CODE_W-1:0] REQ_UNUSED = 2'd3;

   // stimulus size, quiet tail, drain wait and stall watchdog
   localparam int ITEM_TARGET  = 320;
   localparam int TAIL_ITEMS   = 40;
   localparam int DRAIN_CYCLES = 32;
   localparam int STALL_LIMIT  = 4000;
   localparam int REPORT_MAX   = 10;

   // bounds of the signed 32-bit result range, at accumulator width
   localparam logic signed [127:0] ACC_TOP    = 128'sd2147483647;
   localparam logic signed [127:0] ACC_BOTTOM = -128'sd2147483648;

   // fixed-point one and minus one
   localparam logic [VAL_W-1:0] FX_ONE     = 32'h0001_0000;
   localparam logic [VAL_W-1:0] FX_NEG_ONE = 32'hFFFF_0000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   mm4_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   mm4_rsp_type rsp_data;

   // requests waiting to be driven, product elements waiting to arrive
   mm4_req_type pending[$];
   mm4_rsp_type product_due[$];

   // mirror of the two operand stores
   logic signed [VAL_W-1:0] left_elem  [DIM][DIM];
   logic signed [VAL_W-1:0] right_elem [DIM][DIM];

   int   mismatches = 0;
   int   quiet_cycles = 0;
   int   req_gap = 0;
   int   rsp_gap = 0;
   logic req_calm = 1'b0;
   logic rsp_calm = 1'b0;

   matrix_multiply_4x4 dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------

   // every element of left * right, four full-width products summed,
   // floored by the fraction width and clipped to 32 bits
   function automatic void push_product();
      logic signed [127:0] acc;
      logic signed [63:0]  term;
      mm4_rsp_type         elem;
      for (int i = 0; i < DIM; i++) begin
         for (int j = 0; j < DIM; j++) begin
            acc = '0;
            for (int k = 0; k < DIM; k++) begin
               term = left_elem[i][k] * right_elem[k][j];
               acc  = acc + term;
            end
            // arithmetic shift rounds towards minus infinity
            acc = acc >>> FRAC_BITS;
            elem.out_row = ROW_W'(i);
            elem.out_col = ROW_W'(j);
            if (acc > ACC_TOP) begin
               elem.out_value = VAL_MAX;
               elem.saturated = 1'b1;
            end else if (acc < ACC_BOTTOM) begin
               elem.out_value = VAL_MIN;
               elem.saturated = 1'b1;
            end else begin
               elem.out_value = acc[VAL_W-1:0];
               elem.saturated = 1'b0;
            end
            elem.last = (i == DIM - 1) && (j == DIM - 1);
            product_due.push_back(elem);
         end
      end
   endfunction

   // fold one accepted request transaction into the mirror
   function automatic void absorb_request(mm4_req_type item);
      case (item.req_type)
         REQ_WR_LEFT: begin
            left_elem[item.row][item.col] = item.value;
         end
         REQ_WR_RIGHT: begin
            right_elem[item.row][item.col] = item.value;
         end
         REQ_COMPUTE: begin
            push_product();
         end
         default: begin
         end
      endcase
   endfunction

   // compare one result transaction with the oldest product element due
   function automatic void check_element(mm4_rsp_type got);
      mm4_rsp_type want;
      if (product_due.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_MAX)
            $display("unexpected result: row %0d col %0d value %h sat %b last %b",
                     got.out_row, got.out_col, got.out_value, got.saturated, got.last);
         return;
      end
      want = product_due.pop_front();
      if (got.out_row !== want.out_row || got.out_col !== want.out_col ||
          got.out_value !== want.out_value || got.saturated !== want.saturated ||
          got.last !== want.last) begin
         mismatches++;
         if (mismatches <= REPORT_MAX)
            $display("product element mismatch: ",
                     "expected row %0d col %0d value %h sat %b last %b, ",
                     want.out_row, want.out_col, want.out_value, want.saturated, want.last,
                     "got row %0d col %0d value %h sat %b last %b",
                     got.out_row, got.out_col, got.out_value, got.saturated, got.last);
      end
   endfunction

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------

   function automatic void queue_request(logic [CODE_W-1:0] kind, logic [ROW_W-1:0] r,
                                         logic [ROW_W-1:0] c, logic [VAL_W-1:0] v);
      mm4_req_type item;
      item.req_type = kind;
      item.row      = r;
      item.col      = c;
      item.value    = v;
      pending.push_back(item);
   endfunction

   // mostly small magnitudes so that sums stay in range, with some wide values
   // and the corners of the number range
   function automatic logic [VAL_W-1:0] random_element();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 11)
         return VAL_W'($urandom_range(0, (1 << 20) - 1) - (1 << 19));
      else if (pick < 13)
         return VAL_W'($urandom_range(0, (1 << 27) - 1) - (1 << 26));
      else if (pick < 16)
         return $urandom();
      case ($urandom_range(0, 4))
         0:       return VAL_MAX;
         1:       return VAL_MIN;
         2:       return '0;
         3:       return FX_ONE;
         default: return '1;
      endcase
   endfunction

   function automatic void build_stimulus();
      int                 issued;
      int                 burst;
      logic [VAL_W-1:0]   pattern [DIM];
      pattern[0] = '0;
      pattern[1] = '1;
      pattern[2] = FX_ONE;
      pattern[3] = FX_NEG_ONE;

      // an ignored code before anything is loaded
      queue_request(REQ_UNUSED, ROW_W'($urandom()), ROW_W'($urandom()), $urandom());

      // full load: left rows of max, min, small and corner values,
      // right columns likewise, so one product clips high, clips low,
      // floors odd negatives and stays in range
      for (int r = 0; r < DIM; r++) begin
         for (int c = 0; c < DIM; c++) begin
            case (r)
               0:       queue_request(REQ_WR_LEFT, ROW_W'(r), ROW_W'(c), VAL_MAX);
               1:       queue_request(REQ_WR_LEFT, ROW_W'(r), ROW_W'(c), VAL_MIN);
               2:       queue_request(REQ_WR_LEFT, ROW_W'(r), ROW_W'(c),
                                      VAL_W'($urandom_range(0, 4095) - 2048));
               default: queue_request(REQ_WR_LEFT, ROW_W'(r), ROW_W'(c), pattern[c]);
            endcase
         end
      end
      for (int r = 0; r < DIM; r++) begin
         for (int c = 0; c < DIM; c++) begin
            case (c)
               0:       queue_request(REQ_WR_RIGHT, ROW_W'(r), ROW_W'(c), VAL_MAX);
               1:       queue_request(REQ_WR_RIGHT, ROW_W'(r), ROW_W'(c), VAL_MIN);
               2:       queue_request(REQ_WR_RIGHT, ROW_W'(r), ROW_W'(c),
                                      VAL_W'($urandom_range(0, 4095) - 2047));
               default: queue_request(REQ_WR_RIGHT, ROW_W'(r), ROW_W'(c), pattern[r]);
            endcase
         end
      end
      queue_request(REQ_COMPUTE, '0, '0, '0);

      // overwrite a corner of each operand and recompute
      queue_request(REQ_WR_LEFT, 2'd3, 2'd3, VAL_MIN);
      queue_request(REQ_WR_RIGHT, 2'd3, 2'd3, VAL_MAX);
      queue_request(REQ_COMPUTE, 2'd3, 2'd3, '1);
      issued = pending.size() - 1;

      // every entry now holds a value, so computes may fall anywhere:
      // runs of element writes, then mostly a compute, now and then noise
      while (issued < ITEM_TARGET) begin
         burst = $urandom_range(1, 10);
         repeat (burst) begin
            queue_request($urandom_range(0, 1) ? REQ_WR_RIGHT : REQ_WR_LEFT,
                          ROW_W'($urandom()), ROW_W'($urandom()), random_element());
            issued++;
         end
         if ($urandom_range(0, 3) != 0) begin
            queue_request(REQ_COMPUTE, ROW_W'($urandom()), ROW_W'($urandom()), $urandom());
            issued++;
         end
         if ($urandom_range(0, 7) == 0)
            queue_request(REQ_UNUSED, ROW_W'($urandom()), ROW_W'($urandom()), $urandom());
      end
   endfunction

   // ---------------------------------------------------------------
   // request driver
   // ---------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= 0;
      end else begin
         if ($urandom_range(0, 47) == 0)
            req_calm <= ~req_calm;
         if (req_valid && req_ready)
            absorb_request(req_data);
         // next transaction only once the current one is taken
         if (!req_valid || req_ready) begin
            if (req_gap != 0) begin
               req_gap   <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (pending.size() == 0) begin
               req_valid <= 1'b0;
            end else if (!req_calm && pending.size() >= TAIL_ITEMS &&
                         $urandom_range(0, 4) == 0) begin
               // idle burst that begins with this cycle
               req_gap   <= $urandom_range(0, 6);
               req_valid <= 1'b0;
            end else begin
               req_data  <= pending.pop_front();
               req_valid <= 1'b1;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // result monitor and back-pressure
   // ---------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_gap   <= 0;
      end else begin
         if ($urandom_range(0, 47) == 0)
            rsp_calm <= ~rsp_calm;
         if (rsp_valid && rsp_ready)
            check_element(rsp_data);
         if (rsp_gap != 0) begin
            rsp_gap   <= rsp_gap - 1;
            rsp_ready <= 1'b0;
         end else if (!rsp_calm && pending.size() >= TAIL_ITEMS &&
                      $urandom_range(0, 4) == 0) begin
            // stall burst
            rsp_gap   <= $urandom_range(0, 6);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------
   // watchdog: cycles in which neither channel completes a transaction
   // ---------------------------------------------------------------

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------
   // run control
   // ---------------------------------------------------------------

   initial begin
      build_stimulus();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // settle on the falling edge so the driver's updates are visible
      @(negedge clock);
      while (pending.size() != 0 || req_valid || product_due.size() != 0)
         @(negedge clock);
      // let trailing writes finish and catch any stray result
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
